// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion, checked during reset too.
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/srr_pkg.sv =====
package srr_pkg;

   localparam int SEQ_W     = 5;
   localparam int PAYLOAD_W = 64;
   localparam int WIN_W     = 5;
   localparam int WIN_MAX   = 16;

   localparam logic [WIN_W-1:0] WINDOW_RESET = 5'd10;

   localparam logic KIND_DELIVER = 1'b0;
   localparam logic KIND_ACK     = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic                 kind;
      logic [PAYLOAD_W-1:0] payload;
      logic [SEQ_W-1:0]     seq;
      logic                 inw;
      logic                 last;
   } rsp_type;

endpackage

// ===== design/srr_ram.sv =====
module srr_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/selective_repeat_receiver.sv =====
// Selective-repeat ARQ receiver.
// Input channel (req_): one data frame per transaction, a sequence number and a
// 64-bit payload. Output channel (rsp_): for each frame, zero or more in-order
// deliveries (rsp_result_kind 0) followed by one acknowledgment of the frame's
// own sequence number (rsp_result_kind 1, rsp_last 1).
// csr_wr_en/csr_wr_data write the receive window width; write it only while
// the block is idle. Widths above 16 or SEQ_COUNT saturate.
// Flow: a frame is accepted in idle; the drain state then issues reads of
// the in-order filled slots, loads the acknowledgment and returns to idle.
// Deliveries stream one per cycle while the consumer does not stall, from
// the payload RAM, whose single read port and registered read set that figure.
// Deliveries pass the RAM read data register; acknowledgments do not.
// Reset (synchronous) clears all slot-filled flags, the expected sequence
// number and rsp_valid; the window returns to 10. No clearing pass is needed.
// When the consumer stalls, the output register holds its result and the
// RAM read data register holds the next; draining then pauses, and no new
// frame is accepted until the current frame's acknowledgment is registered.
module selective_repeat_receiver #(
   parameter int SEQ_COUNT = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [srr_pkg::SEQ_W-1:0]     req_frame_seq,
   input  logic [srr_pkg::PAYLOAD_W-1:0] req_frame_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_result_kind,
   output logic [srr_pkg::PAYLOAD_W-1:0] rsp_delivered_payload,
   output logic [srr_pkg::SEQ_W-1:0]     rsp_ack_seq,
   output logic                          rsp_in_window,
   output logic                          rsp_last,
   input  logic                          csr_wr_en,
   input  logic [srr_pkg::WIN_W-1:0]     csr_wr_data
);

   import srr_pkg::*;

   localparam int IW   = $clog2(SEQ_COUNT);
   localparam int CW   = ((IW > SEQ_W) ? IW : SEQ_W) + 1;
   localparam int WCAP = (SEQ_COUNT < WIN_MAX) ? SEQ_COUNT : WIN_MAX;
   localparam logic [WIN_W-1:0] WIN_CAP  = WIN_W'(WCAP);
   localparam logic [CW-1:0]    SEQ_LIM  = CW'(SEQ_COUNT);
   localparam logic [IW-1:0]    SEQ_LAST = IW'(SEQ_COUNT - 1);

   state_type              state_ff, state_in;
   logic [IW-1:0]          exp_ff, exp_in;
   logic [SEQ_COUNT-1:0]   filled_ff, filled_in;
   logic [WIN_W-1:0]       window_ff, window_in;
   logic [SEQ_W-1:0]       fseq_ff, fseq_in;
   logic                   finw_ff, finw_in;
   logic                   rd_valid_ff, rd_valid_in;
   logic [SEQ_W-1:0]       dl_slot_ff, dl_slot_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   accept;
   logic [CW-1:0]          seq_ext;
   logic [CW-1:0]          exp_ext;
   logic [CW-1:0]          gap;
   logic                   seq_ok;
   logic [IW-1:0]          s_idx;
   logic [WIN_W-1:0]       win_eff;
   logic                   inw_now;
   logic                   store;
   logic                   head_filled;
   logic                   out_free;
   logic                   load_dl;
   logic                   issue;
   logic                   load_ack;
   logic [PAYLOAD_W-1:0]   rd_data;

   srr_ram #(
      .WIDTH (PAYLOAD_W),
      .DEPTH (SEQ_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (store),
      .wr_addr (s_idx),
      .wr_data (req_frame_payload),
      .rd_en   (issue),
      .rd_addr (exp_ff),
      .rd_data (rd_data)
   );

   // window check
   always_comb begin
      seq_ext = CW'(req_frame_seq);
      exp_ext = CW'(exp_ff);
      seq_ok  = seq_ext < SEQ_LIM;
      s_idx   = seq_ext[IW-1:0];
      if (seq_ext >= exp_ext) begin
         gap = seq_ext - exp_ext;
      end else begin
         gap = seq_ext + SEQ_LIM - exp_ext;
      end
      win_eff = (window_ff > WIN_CAP) ? WIN_CAP : window_ff;
      inw_now = seq_ok && (gap < CW'(win_eff));
   end

   assign head_filled = filled_ff[exp_ff];
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign load_dl     = rd_valid_ff && out_free;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      issue     = 1'b0;
      load_ack  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (finw_ff && head_filled) begin
               issue = !rd_valid_ff || load_dl;
            end else if (!rd_valid_ff && out_free) begin
               load_ack = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign accept = req_valid && req_ready;
   assign store  = accept && inw_now && !filled_ff[s_idx];

   always_comb begin
      filled_in = filled_ff;
      if (store) begin
         filled_in[s_idx] = 1'b1;
      end
      if (issue) begin
         filled_in[exp_ff] = 1'b0;
      end

      exp_in     = exp_ff;
      dl_slot_in = dl_slot_ff;
      if (issue) begin
         exp_in     = (exp_ff == SEQ_LAST) ? '0 : exp_ff + 1'b1;
         dl_slot_in = exp_ext[SEQ_W-1:0];
      end

      fseq_in = fseq_ff;
      finw_in = finw_ff;
      if (accept) begin
         fseq_in = req_frame_seq;
         finw_in = inw_now;
      end

      window_in = csr_wr_en ? csr_wr_data : window_ff;

      if (issue) begin
         rd_valid_in = 1'b1;
      end else if (load_dl) begin
         rd_valid_in = 1'b0;
      end else begin
         rd_valid_in = rd_valid_ff;
      end

      rsp_in = rsp_ff;
      if (load_dl) begin
         rsp_in.kind    = KIND_DELIVER;
         rsp_in.payload = rd_data;
         rsp_in.seq     = dl_slot_ff;
         rsp_in.inw     = 1'b1;
         rsp_in.last    = 1'b0;
      end else if (load_ack) begin
         rsp_in.kind    = KIND_ACK;
         rsp_in.payload = '0;
         rsp_in.seq     = fseq_ff;
         rsp_in.inw     = finw_ff;
         rsp_in.last    = 1'b1;
      end

      if (load_dl || load_ack) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ff       <= '0;
         filled_ff    <= '0;
         window_ff    <= WINDOW_RESET;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         exp_ff       <= exp_in;
         filled_ff    <= filled_in;
         window_ff    <= window_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fseq_ff    <= fseq_in;
      finw_ff    <= finw_in;
      dl_slot_ff <= dl_slot_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_result_kind       = rsp_ff.kind;
   assign rsp_delivered_payload = rsp_ff.payload;
   assign rsp_ack_seq           = rsp_ff.seq;
   assign rsp_in_window         = rsp_ff.inw;
   assign rsp_last              = rsp_ff.last;

endmodule

// ===== design/srr_checker.sv =====
`include "assert_macros.svh"

module srr_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [srr_pkg::SEQ_W-1:0]     req_frame_seq,
   input logic [srr_pkg::PAYLOAD_W-1:0] req_frame_payload,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_result_kind,
   input logic [srr_pkg::PAYLOAD_W-1:0] rsp_delivered_payload,
   input logic [srr_pkg::SEQ_W-1:0]     rsp_ack_seq,
   input logic                          rsp_in_window,
   input logic                          rsp_last,
   input logic                          csr_wr_en,
   input logic [srr_pkg::WIN_W-1:0]     csr_wr_data
);

   import srr_pkg::*;

   `ASSERT_CLK(a_reset_idle, clock, reset |=> !rsp_valid && req_ready, "reset not idle")
   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_delivered_payload) && $stable(rsp_ack_seq) && $stable(rsp_result_kind) && $stable(rsp_last), "stalled transaction changed")
   `ASSERT_CLK_RST(a_ack_form, clock, reset, rsp_valid && rsp_result_kind == KIND_ACK |-> rsp_last && rsp_delivered_payload == '0, "bad acknowledgment")
   `ASSERT_CLK_RST(a_dl_form, clock, reset, rsp_valid && rsp_result_kind == KIND_DELIVER |-> rsp_in_window && !rsp_last, "bad delivery")

endmodule

bind selective_repeat_receiver srr_checker u_srr_checker (.*);
